FILE: sv/tcea_pkg.sv
// shared types and constants for the two-class exclusion arbiter
`default_nettype none
package tcea_pkg;

  localparam int CntW = 8;
  localparam logic [CntW-1:0] MAX_COUNT = 8'd255;
  localparam logic [7:0] QUOTA_RESET = 8'd4;
  localparam logic [8:0] SERVED_SAT = 9'd255;

  typedef enum logic {
    CMD_ARRIVE = 1'b0,
    CMD_LEAVE  = 1'b1
  } cmd_t;

  typedef logic [CntW-1:0] cnt_t;

  typedef struct packed {
    logic       admitted_now;
    logic [7:0] released_count;
    logic       error_flag;
  } result_t;

endpackage
`default_nettype wire

FILE: sv/tcea_core.sv
// class counters and the closed-form arrive / leave update
`default_nettype none
module tcea_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire tcea_pkg::cmd_t    command,
  input  wire logic              requester_class,
  input  wire logic [7:0]        turn_quota,
  output tcea_pkg::result_t      result
);
  import tcea_pkg::*;

  cnt_t occupied      [2];
  cnt_t waiting       [2];
  cnt_t served        [2];
  cnt_t occupied_next [2];
  cnt_t waiting_next  [2];
  cnt_t served_next   [2];

  logic c;
  logic o;
  logic blocked;
  cnt_t k;
  cnt_t room;
  logic [8:0] headroom;
  logic [8:0] bump;

  always_comb begin
    c = requester_class;
    o = ~requester_class;
    for (int i = 0; i < 2; i++) begin
      occupied_next[i] = occupied[i];
      waiting_next[i]  = waiting[i];
      served_next[i]   = served[i];
    end
    result = '0;
    blocked = (occupied[o] != '0) ||
              ((waiting[o] != '0) && (served[c] >= turn_quota));
    room = turn_quota - served[o];
    k = '0;
    if ((occupied[c] == cnt_t'(1)) && (command == CMD_LEAVE)) begin
      if (waiting[c] == '0) begin
        k = waiting[o];
      end else if (served[o] < turn_quota) begin
        k = (waiting[o] < room) ? waiting[o] : room;
      end
    end
    headroom = {1'b0, MAX_COUNT} - {1'b0, occupied[o]};
    bump = {1'b0, served[o]} + {1'b0, k};

    case (command)
      CMD_ARRIVE: begin
        if (blocked) begin
          if (waiting[c] >= MAX_COUNT) begin
            result.error_flag = 1'b1;
          end else begin
            waiting_next[c] = waiting[c] + cnt_t'(1);
          end
        end else begin
          if (occupied[c] >= MAX_COUNT) begin
            result.error_flag = 1'b1;
          end else begin
            occupied_next[c] = occupied[c] + cnt_t'(1);
            served_next[o] = '0;
            // saturating bump of this class's turn count, only while the other class waits
            if ((waiting[o] != '0) && (served[c] != cnt_t'(SERVED_SAT))) begin
              served_next[c] = served[c] + cnt_t'(1);
            end
            result.admitted_now = 1'b1;
          end
        end
      end
      CMD_LEAVE: begin
        if (occupied[c] == '0) begin
          result.error_flag = 1'b1;
        end else if ({1'b0, k} > headroom) begin
          result.error_flag = 1'b1;
        end else begin
          occupied_next[c] = occupied[c] - cnt_t'(1);
          if (k != '0) begin
            occupied_next[o] = occupied[o] + k;
            waiting_next[o]  = waiting[o] - k;
            served_next[c]   = '0;
            if (waiting[c] != '0) begin
              served_next[o] = (bump > SERVED_SAT) ? cnt_t'(SERVED_SAT) : bump[7:0];
            end
          end
          result.released_count = k;
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        occupied[i] <= '0;
        waiting[i]  <= '0;
        served[i]   <= '0;
      end
    end else if (advance) begin
      for (int i = 0; i < 2; i++) begin
        occupied[i] <= occupied_next[i];
        waiting[i]  <= waiting_next[i];
        served[i]   <= served_next[i];
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/two_class_exclusion_arbiter.sv
// path: an accepted beat passes through the input reg and then the result reg
// throughput: one beat per cycle while out_ready is high, set by the counter update in tcea_core
// a waiting result stalls the input once the input reg also holds a beat
// reset: synchronous active-high rst clears all class counters, valid bits and sets
// turn_quota to 4
`default_nettype none
module two_class_exclusion_arbiter (
  input  wire logic       clk,
  input  wire logic       rst,
  // request channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       command,
  input  wire logic       requester_class,
  // result channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            admitted_now,
  output logic [7:0]      released_count,
  output logic            error_flag,
  // quota register write
  input  wire logic       cfg_write,
  input  wire logic [7:0] cfg_data
);
  import tcea_pkg::*;

  logic [7:0] turn_quota;

  // input stage
  logic       req_valid;
  cmd_t       req_command;
  logic       req_class;

  // result stage
  result_t    res;
  result_t    res_q;

  logic       advance;

  // the input beat moves on when the result reg is empty or being drained
  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_quota <= QUOTA_RESET;
    end else if (cfg_write) begin
      turn_quota <= cfg_data;
    end
  end

  // input register: payload without reset
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_command <= cmd_t'(command);
      req_class   <= requester_class;
    end
  end

  // counters update exactly once per beat, at the same edge the result is captured
  tcea_core u_core (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .command         (req_command),
    .requester_class (req_class),
    .turn_quota      (turn_quota),
    .result          (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign admitted_now   = res_q.admitted_now;
  assign released_count = res_q.released_count;
  assign error_flag     = res_q.error_flag;

endmodule
`default_nettype wire
